### rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg: shared types and helpers of the line rasteriser
// payload structs, controller to datapath command and status, coordinate clamp
// ----------------------------------------------------------------------------
package lr_pkg;

   localparam int GRID_SIZE = 64;
   localparam int COORD_W   = 6;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [7:0]         glyph;
      logic [15:0]        paint;
   } lr_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [7:0]         pixel_glyph;
      logic [15:0]        pixel_paint;
      logic               last_pixel;
   } lr_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture a new segment
      logic setup;   // derive slope terms
      logic step;    // emit one pixel and advance
   } lr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_step;
   } lr_status_type;

   // saturate a coordinate to the grid
   function automatic logic [COORD_W-1:0] lr_clamp(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] c;
      c = v;
      if ({1'b0, v} >= (COORD_W+1)'(GRID_SIZE)) begin
         c = COORD_W'(GRID_SIZE - 1);
      end
      return c;
   endfunction

endpackage

### rtl/lr_ctrl.sv
// ----------------------------------------------------------------------------
// lr_ctrl: sequencing of the line rasteriser
// idle, a set-up state, then one pixel per cycle until the last one
// ----------------------------------------------------------------------------
module lr_ctrl
   import lr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  lr_status_type status,
   output lr_cmd_type    cmd,
   output logic          busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign cmd.load  = start && !busy_ff;
   assign cmd.setup = (state_ff == ST_SETUP);
   assign cmd.step  = (state_ff == ST_RUN);
   assign busy      = busy_ff;

endmodule

### rtl/lr_datapath.sv
// ----------------------------------------------------------------------------
// lr_datapath: segment registers, slope set-up and incremental rounding
// keeps quotient and remainder of the rounded minor offset, no divider
// ----------------------------------------------------------------------------
module lr_datapath
   import lr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lr_cmd_type    cmd,
   input  lr_req_type    req_data,
   output lr_status_type status,
   output logic          rsp_strobe,
   output lr_rsp_type    rsp_data
);

   // captured segment
   logic [COORD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [7:0]         glyph_ff;
   logic [15:0]        paint_ff;

   // stepping state
   logic               steep_ff;
   logic [COORD_W-1:0] major_ff, major_in;
   logic [COORD_W-1:0] span_ff, span_in;
   logic [COORD_W-1:0] cnt_ff;
   logic [COORD_W-1:0] base_ff, base_in;
   logic signed [6:0]  q_ff, q_in, q_step;
   logic signed [8:0]  r_ff, r_in, r_step, r_sum;
   logic [6:0]         two_d_ff, two_d_in;
   logic signed [7:0]  delta_ff, delta_in;

   // output register
   logic               strobe_ff;
   lr_rsp_type         rsp_ff;

   // set-up terms
   logic signed [6:0]  dx, dy, n;
   logic [COORD_W-1:0] adx, ady, d_abs;
   logic               steep_in, d_neg;
   logic [COORD_W-1:0] minor;

   always_comb begin
      dx       = $signed({1'b0, x2_ff}) - $signed({1'b0, x1_ff});
      dy       = $signed({1'b0, y2_ff}) - $signed({1'b0, y1_ff});
      adx      = dx[6] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ady      = dy[6] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      steep_in = ady > adx;
      if (steep_in) begin
         major_in = (y1_ff < y2_ff) ? y1_ff : y2_ff;
         span_in  = ady;
         base_in  = x1_ff;
         n        = dx;
         d_neg    = dy[6];
         d_abs    = ady;
      end else begin
         major_in = (x1_ff < x2_ff) ? x1_ff : x2_ff;
         span_in  = adx;
         base_in  = y1_ff;
         n        = dy;
         d_neg    = dx[6];
         d_abs    = adx;
      end
      two_d_in = {d_abs, 1'b0};
      // stepping from the far end walks the fraction downwards
      delta_in = d_neg ? -{n, 1'b0} : {n, 1'b0};
      q_in     = d_neg ? n : 7'sd0;
      r_in     = $signed({3'b000, d_abs});
   end

   // one remainder correction per step, |delta| never exceeds 2|d|
   always_comb begin
      r_sum  = r_ff + 9'(delta_ff);
      r_step = r_sum;
      q_step = q_ff;
      if (r_sum >= $signed({2'b00, two_d_ff})) begin
         r_step = r_sum - $signed({2'b00, two_d_ff});
         q_step = q_ff + 7'sd1;
      end else if (r_sum < 9'sd0) begin
         r_step = r_sum + $signed({2'b00, two_d_ff});
         q_step = q_ff - 7'sd1;
      end
      minor = base_ff + q_ff[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x1_ff    <= lr_clamp(req_data.start_x);
         y1_ff    <= lr_clamp(req_data.start_y);
         x2_ff    <= lr_clamp(req_data.end_x);
         y2_ff    <= lr_clamp(req_data.end_y);
         glyph_ff <= req_data.glyph;
         paint_ff <= req_data.paint;
      end
      if (cmd.setup) begin
         steep_ff <= steep_in;
         major_ff <= major_in;
         span_ff  <= span_in;
         cnt_ff   <= '0;
         base_ff  <= base_in;
         q_ff     <= q_in;
         r_ff     <= r_in;
         two_d_ff <= two_d_in;
         delta_ff <= delta_in;
      end else if (cmd.step) begin
         major_ff <= major_ff + COORD_W'(1);
         cnt_ff   <= cnt_ff + COORD_W'(1);
         q_ff     <= q_step;
         r_ff     <= r_step;
      end
      if (cmd.step) begin
         rsp_ff.pixel_x     <= steep_ff ? minor : major_ff;
         rsp_ff.pixel_y     <= steep_ff ? major_ff : minor;
         rsp_ff.pixel_glyph <= glyph_ff;
         rsp_ff.pixel_paint <= paint_ff;
         rsp_ff.last_pixel  <= (cnt_ff == span_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.step;
      end
   end

   assign status.last_step = (cnt_ff == span_ff);
   assign rsp_strobe       = strobe_ff;
   assign rsp_data         = rsp_ff;

endmodule

### rtl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer: rational-rounding line rasteriser on a 64 by 64 grid
//
// a segment is taken as one beat on req_data at a clock edge where start is
// high and busy is low; busy rises in the next cycle and stays high while
// the segment is walked
// the cycle after acceptance goes to the slope set-up, then one pixel beat a
// cycle leaves on rsp_data with rsp_strobe high, in ascending order of the
// major axis, last_pixel marking the final one
// the first pixel passes the set-up state, a run step and the output register;
// busy stays high through the last run step and the next segment is taken
// once busy is low again, so a segment is walked to its end before the next
// is accepted; set-up, one pixel a cycle and the accepting cycle set the pace
// the last pixel sits in the output register while busy is already low, so
// the next segment may be accepted in that same cycle
// each pixel beat is shown for exactly one cycle; the receiver cannot stall
// synchronous reset returns the sequencer to idle and drops the strobe; a
// segment in flight is abandoned
// ----------------------------------------------------------------------------
module line_rasterizer
   import lr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  lr_req_type req_data,
   output logic       rsp_strobe,
   output lr_rsp_type rsp_data
);

   lr_cmd_type    cmd;
   lr_status_type status;

   // sequencer: idle, set-up, run
   lr_ctrl u_lr_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // coordinates, slope terms and the output register
   lr_datapath u_lr_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/lr_checker.sv
// ----------------------------------------------------------------------------
// lr_checker: port-level checks of the line rasteriser
// beat ordering around acceptance and line end
// ----------------------------------------------------------------------------
module lr_checker
   import lr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input lr_rsp_type rsp_data
);

   // accepted segment makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after acceptance");

   // set-up cycle carries no pixel
   a_quiet_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_strobe)
      else $error("pixel beat during set-up");

   // pixels of one line come without gaps, same glyph and paint
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_pixel |=>
         rsp_strobe && $stable(rsp_data.pixel_glyph) && $stable(rsp_data.pixel_paint))
      else $error("gap or attribute change inside a line");

   // nothing follows the last pixel directly
   a_end_of_line: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_pixel |=> !rsp_strobe)
      else $error("pixel beat right after last pixel");

   // when idle only a last pixel may still be shown
   a_idle_only_last: assert property (@(posedge clock) disable iff (reset)
      !busy && rsp_strobe |-> rsp_data.last_pixel)
      else $error("non-final pixel while idle");

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the line rasteriser
// segments go in as single command beats under start/busy; every pixel beat
// on the strobe is checked against an independent rational-rounding
// prediction, oldest first
// ----------------------------------------------------------------------------
module tb
   import lr_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;  // several times the slowest legal run
   localparam int RANDOM_LINES = 460;
   localparam int CALM_TAIL    = 60;      // final lines drawn back to back
   localparam int DRAIN_CYCLES = 80;      // beyond the longest segment walk

   // ------------------------------------------------------------------------
   // scoreboard: predicts the pixel walk of each accepted segment and
   // compares strobed pixels against it in order
   // ------------------------------------------------------------------------
   class pixel_scoreboard;
      lr_rsp_type  pending_pixels[$];
      int unsigned mismatches;

      // base + floor(t*n/d + 1/2), exact on integers, d nonzero
      function int rounded_minor(int base, int t, int n, int d);
         int num;
         int den;
         int q;
         num = 2 * t * n + d;
         den = 2 * d;
         if (den < 0) begin
            num = -num;
            den = -den;
         end
         q = num / den;
         if ((num % den) != 0 && num < 0) begin
            q = q - 1;
         end
         return base + q;
      endfunction

      // accepted segment: queue up every pixel it must produce
      function void note_segment(lr_req_type seg);
         int         x1, y1, x2, y2, dx, dy;
         int         lo, span, major, px, py;
         bit         steep;
         lr_rsp_type pix;
         x1 = seg.start_x;
         y1 = seg.start_y;
         x2 = seg.end_x;
         y2 = seg.end_y;
         dx = x2 - x1;
         dy = y2 - y1;
         steep = ((dy < 0) ? -dy : dy) > ((dx < 0) ? -dx : dx);
         if (steep) begin
            lo   = (y1 < y2) ? y1 : y2;
            span = (dy < 0) ? -dy : dy;
         end else begin
            lo   = (x1 < x2) ? x1 : x2;
            span = (dx < 0) ? -dx : dx;
         end
         for (int i = 0; i <= span; i++) begin
            major = lo + i;
            if (steep) begin
               py = major;
               px = rounded_minor(x1, major - y1, dx, dy);
            end else begin
               px = major;
               py = (dx == 0) ? y1 : rounded_minor(y1, major - x1, dy, dx);
            end
            pix.pixel_x     = COORD_W'(px);
            pix.pixel_y     = COORD_W'(py);
            pix.pixel_glyph = seg.glyph;
            pix.pixel_paint = seg.paint;
            pix.last_pixel  = (i == span);
            pending_pixels.push_back(pix);
         end
      endfunction

      function void check_pixel(lr_rsp_type got);
         lr_rsp_type want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected pixel: x=%0d y=%0d glyph=%h paint=%h last=%b",
                        got.pixel_x, got.pixel_y, got.pixel_glyph, got.pixel_paint,
                        got.last_pixel);
            end
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
             got.pixel_glyph !== want.pixel_glyph ||
             got.pixel_paint !== want.pixel_paint ||
             got.last_pixel !== want.last_pixel) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("pixel mismatch: expected x=%0d y=%0d glyph=%h paint=%h last=%b",
                        want.pixel_x, want.pixel_y, want.pixel_glyph, want.pixel_paint,
                        want.last_pixel);
               $display("                got      x=%0d y=%0d glyph=%h paint=%h last=%b",
                        got.pixel_x, got.pixel_y, got.pixel_glyph, got.pixel_paint,
                        got.last_pixel);
            end
         end
      endfunction

      function bit failed();
         return (mismatches != 0) || (pending_pixels.size() != 0);
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------------
   logic       clock    = 1'b0;
   logic       reset    = 1'b1;
   logic       start    = 1'b0;
   lr_req_type req_data = '0;
   logic       busy;
   logic       rsp_strobe;
   lr_rsp_type rsp_data;

   pixel_scoreboard sb = new;
   int unsigned     cycle_count = 0;

   line_rasterizer uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // monitors: both sample pre-edge values, so ordering within the step is moot
   // ------------------------------------------------------------------------
   // a segment beat is taken wherever start is high and busy is low
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         sb.note_segment(req_data);
      end
   end

   // pixel beats cannot be held off, so each strobe is one accepted pixel
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_pixel(rsp_data);
      end
   end

   // watchdog against a hung sequencer
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL line_rasterizer");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------------
   // idle for gap cycles, then offer the segment until busy is seen low at an
   // edge; with no gap start simply stays high into the next segment, which
   // also lands the offer on the cycle where the last pixel is still out
   task automatic draw_segment(input lr_req_type seg, input int unsigned gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= seg;
      do @(posedge clock); while (busy);
   endtask

   function automatic lr_req_type make_segment(int x1, int y1, int x2, int y2,
                                               int g, int p);
      lr_req_type seg;
      seg.start_x = COORD_W'(x1);
      seg.start_y = COORD_W'(y1);
      seg.end_x   = COORD_W'(x2);
      seg.end_y   = COORD_W'(y2);
      seg.glyph   = 8'(g);
      seg.paint   = 16'(p);
      return seg;
   endfunction

   // coordinate a few cells away from v, kept on the grid
   function automatic int nearby(int v);
      int c;
      c = v + int'($urandom_range(0, 10)) - 5;
      if (c < 0) c = 0;
      if (c > GRID_SIZE - 1) c = GRID_SIZE - 1;
      return c;
   endfunction

   // mostly arbitrary segments, with short ones, axis-aligned ones,
   // diagonals and single points mixed in
   function automatic lr_req_type random_segment();
      int unsigned flavour;
      int          x1, y1, x2, y2, d;
      flavour = $urandom_range(0, 9);
      x1 = $urandom_range(0, GRID_SIZE - 1);
      y1 = $urandom_range(0, GRID_SIZE - 1);
      x2 = $urandom_range(0, GRID_SIZE - 1);
      y2 = $urandom_range(0, GRID_SIZE - 1);
      case (flavour)
         6, 7: begin
            x2 = nearby(x1);
            y2 = nearby(y1);
         end
         8: begin
            if ($urandom_range(0, 1)) x2 = x1;
            else y2 = y1;
         end
         9: begin
            if ($urandom_range(0, 1)) begin
               x2 = x1;
               y2 = y1;
            end else begin
               d  = $urandom_range(0, GRID_SIZE - 1);
               x2 = (x1 + d > GRID_SIZE - 1) ? x1 - d : x1 + d;
               y2 = (y1 + d > GRID_SIZE - 1) ? y1 - d : y1 + d;
               if (x2 < 0) x2 = 0;
               if (y2 < 0) y2 = 0;
            end
         end
         default: ;
      endcase
      return make_segment(x1, y1, x2, y2, $urandom, $urandom);
   endfunction

   function automatic int unsigned random_gap(bit calm);
      if (calm || $urandom_range(0, 3) != 0) return 0;
      return $urandom_range(1, 12);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single points at both grid corners with extreme attributes
      draw_segment(make_segment( 0,  0,  0,  0, 8'h00, 16'h0000), 0);
      draw_segment(make_segment(63, 63, 63, 63, 8'hff, 16'hffff), 0);
      // full-length horizontal and vertical walks, both directions
      draw_segment(make_segment( 0, 10, 63, 10, 8'h55, 16'haaaa), 2);
      draw_segment(make_segment(63, 20,  0, 20, 8'haa, 16'h5555), 0);
      draw_segment(make_segment(30,  0, 30, 63, 8'h0f, 16'hf0f0), 0);
      draw_segment(make_segment(40, 63, 40,  0, 8'hf0, 16'h0f0f), 5);
      // diagonals: equal differences are not steep
      draw_segment(make_segment( 0,  0, 63, 63, 8'h01, 16'h8001), 0);
      draw_segment(make_segment(63,  0,  0, 63, 8'h80, 16'h7ffe), 0);
      // exact half: minor coordinate midway between two cells rounds up
      draw_segment(make_segment( 0,  0,  2,  1, 8'h12, 16'h1234), 0);
      draw_segment(make_segment( 2,  1,  0,  0, 8'h34, 16'h5678), 1);
      draw_segment(make_segment( 0,  0,  1,  2, 8'h56, 16'h9abc), 0);
      draw_segment(make_segment( 1,  2,  0,  0, 8'h78, 16'hdef0), 0);
      draw_segment(make_segment(10, 13, 20, 10, 8'h9a, 16'h0001), 0);
      // just off the diagonal either way
      draw_segment(make_segment( 0,  0, 63, 62, 8'hbc, 16'h8000), 0);
      draw_segment(make_segment( 0,  0, 62, 63, 8'hde, 16'h7fff), 3);
      // steep with a negative minor slope, and a very shallow slope
      draw_segment(make_segment(10, 40, 13,  0, 8'h7f, 16'hfffe), 0);
      draw_segment(make_segment( 0, 32, 63, 31, 8'hfe, 16'h00ff), 0);
      // single-step spans and a short diagonal
      draw_segment(make_segment(20, 20, 21, 20, 8'h3c, 16'hff00), 0);
      draw_segment(make_segment(20, 20, 20, 21, 8'hc3, 16'h3c3c), 0);
      draw_segment(make_segment( 3,  7,  7,  3, 8'h66, 16'hc3c3), 0);

      // random part, back to back at the tail
      for (int n = 0; n < RANDOM_LINES; n++) begin
         draw_segment(random_segment(), random_gap(n >= RANDOM_LINES - CALM_TAIL));
      end
      start <= 1'b0;

      // drain, then allow for any stray beat after the last expected pixel
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failed()) begin
         if (sb.pending_pixels.size() != 0) begin
            $display("%0d expected pixels never arrived", sb.pending_pixels.size());
         end
         $display("FAIL line_rasterizer");
      end else begin
         $display("PASS line_rasterizer");
      end
      $finish;
   end

endmodule

### sim.f
rtl/lr_pkg.sv
rtl/lr_ctrl.sv
rtl/lr_datapath.sv
rtl/line_rasterizer.sv
rtl/lr_checker.sv
sim/tb.sv
